### rtl/spfs_pkg.sv
// Shared types and constants for the smallest-prime-factor sieve.
// Used by the controller, the datapath, the top level and the checker.
// Depends on nothing.
package spfs_pkg;

	localparam int unsigned VW          = 13;
	localparam int unsigned CW          = VW + 1;
	localparam int unsigned VAL_MAX     = (1 << VW) - 1;
	localparam int unsigned MAX_N_DEF   = 4096;
	localparam logic [VW-1:0] LIMIT_RST = VW'(4096);

	localparam logic CMD_BUILD = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_UNBUILT = 2'd2;

	typedef struct packed {
		logic start_build;
		logic start_query;
		logic init_step;
		logic p_read;
		logic p_next;
		logic mark_begin;
		logic mark_step;
		logic load_build;
		logic load_query;
	} spfs_cmd_t;

	typedef struct packed {
		logic init_last;
		logic p_over;
		logic p_is_prime;
		logic mark_done;
	} spfs_stat_t;

endpackage

### rtl/spfs_ctrl.sv
// Controller state machine of the smallest-prime-factor sieve.
// Sequences build and query transactions and owns the handshakes.
// Depends on spfs_pkg.
module spfs_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 command,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  spfs_pkg::spfs_stat_t stat,
	output spfs_pkg::spfs_cmd_t  cmd
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_INIT = 7'b0000010,
		S_PRD  = 7'b0000100,
		S_PCHK = 7'b0001000,
		S_MARK = 7'b0010000,
		S_FIN  = 7'b0100000,
		S_QRES = 7'b1000000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;
	logic   load;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;
	assign load      = cmd.load_build || cmd.load_query;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (command == spfs_pkg::CMD_QUERY) begin
						cmd.start_query = 1'b1;
						state_d         = S_QRES;
					end else begin
						cmd.start_build = 1'b1;
						state_d         = S_INIT;
					end
				end
			end
			S_INIT: begin
				cmd.init_step = 1'b1;
				if (stat.init_last) begin
					state_d = S_PRD;
				end
			end
			S_PRD: begin
				if (stat.p_over) begin
					state_d = S_FIN;
				end else begin
					cmd.p_read = 1'b1;
					state_d    = S_PCHK;
				end
			end
			S_PCHK: begin
				if (stat.p_is_prime) begin
					cmd.mark_begin = 1'b1;
					state_d        = S_MARK;
				end else begin
					cmd.p_next = 1'b1;
					state_d    = S_PRD;
				end
			end
			S_MARK: begin
				if (stat.mark_done) begin
					cmd.p_next = 1'b1;
					state_d    = S_PRD;
				end else begin
					cmd.mark_step = 1'b1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					cmd.load_build = 1'b1;
					state_d        = S_IDLE;
				end
			end
			S_QRES: begin
				if (out_free) begin
					cmd.load_query = 1'b1;
					state_d        = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/spfs_dp.sv
// Datapath of the smallest-prime-factor sieve: limit register, factor table
// memory, sieve counters and the result register.
// Depends on spfs_pkg; driven by spfs_ctrl.
module spfs_dp #(
	parameter int unsigned MAX_N = spfs_pkg::MAX_N_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [spfs_pkg::VW-1:0]     cfg_wdata,
	input  logic [spfs_pkg::VW-1:0]     query_value,
	input  spfs_pkg::spfs_cmd_t         cmd,
	output spfs_pkg::spfs_stat_t        stat,
	output logic [spfs_pkg::VW-1:0]     smallest_factor,
	output logic                        is_prime,
	output logic [1:0]                  status
);

	localparam int unsigned VW    = spfs_pkg::VW;
	localparam int unsigned CW    = spfs_pkg::CW;
	localparam int unsigned TOP   = (MAX_N < spfs_pkg::VAL_MAX) ? MAX_N : spfs_pkg::VAL_MAX;
	localparam int unsigned DEPTH = TOP + 1;
	localparam int unsigned AW    = $clog2(DEPTH);

	logic [VW-1:0] table_mem [DEPTH];

	logic [VW-1:0] sieve_limit_q;
	logic [VW-1:0] lim_q;
	logic [VW-1:0] built_lim_q;
	logic          built_q;
	logic [VW-1:0] v_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] p_q;
	logic [CW-1:0] psq_q;
	logic [CW-1:0] j_q;
	logic [CW-1:0] jd_q;
	logic          pend_q;
	logic [VW-1:0] rd_q;
	logic [VW-1:0] sf_q;
	logic          prime_q;
	logic [1:0]    st_q;

	logic          j_in;
	logic          hit;
	logic          we;
	logic [AW-1:0] wa;
	logic [VW-1:0] wd;
	logic          re;
	logic [AW-1:0] ra;
	logic [VW-1:0] lim_new;

	assign lim_new = (sieve_limit_q > VW'(TOP)) ? VW'(TOP) : sieve_limit_q;
	assign j_in    = (j_q <= {1'b0, lim_q});
	assign hit     = pend_q && ({1'b0, rd_q} == jd_q);

	assign stat.init_last  = (i_q == {1'b0, lim_q});
	assign stat.p_over     = (psq_q > {1'b0, lim_q});
	assign stat.p_is_prime = ({1'b0, rd_q} == p_q);
	assign stat.mark_done  = !j_in && !pend_q;

	always_comb begin
		we = 1'b0;
		wa = AW'(i_q);
		wd = (i_q >= CW'(4) && !i_q[0]) ? VW'(2) : VW'(i_q);
		if (cmd.init_step) begin
			we = 1'b1;
		end else if (cmd.mark_step && hit) begin
			we = 1'b1;
			wa = AW'(jd_q);
			wd = VW'(p_q);
		end
	end

	always_comb begin
		re = 1'b0;
		ra = AW'(query_value);
		if (cmd.start_query) begin
			re = 1'b1;
		end else if (cmd.p_read) begin
			re = 1'b1;
			ra = AW'(p_q);
		end else if (cmd.mark_step && j_in) begin
			re = 1'b1;
			ra = AW'(j_q);
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			table_mem[wa] <= wd;
		end
		if (re) begin
			rd_q <= table_mem[ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sieve_limit_q <= spfs_pkg::LIMIT_RST;
			built_q       <= 1'b0;
			built_lim_q   <= '0;
			pend_q        <= 1'b0;
		end else begin
			if (cfg_we) begin
				sieve_limit_q <= cfg_wdata;
			end
			if (cmd.load_build) begin
				built_q     <= 1'b1;
				built_lim_q <= lim_q;
			end
			if (cmd.mark_begin) begin
				pend_q <= 1'b0;
			end else if (cmd.mark_step) begin
				pend_q <= j_in;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_build) begin
			lim_q <= lim_new;
			i_q   <= '0;
		end
		if (cmd.start_query) begin
			v_q <= query_value;
		end
		if (cmd.init_step) begin
			i_q   <= i_q + CW'(1);
			p_q   <= CW'(3);
			psq_q <= CW'(9);
		end
		if (cmd.p_next) begin
			p_q   <= p_q + CW'(2);
			psq_q <= psq_q + (p_q << 2) + CW'(4);
		end
		if (cmd.mark_begin) begin
			j_q <= psq_q;
		end
		if (cmd.mark_step && j_in) begin
			j_q  <= j_q + p_q;
			jd_q <= j_q;
		end
		if (cmd.load_build) begin
			sf_q    <= '0;
			prime_q <= 1'b0;
			st_q    <= spfs_pkg::ST_OK;
		end
		if (cmd.load_query) begin
			sf_q    <= '0;
			prime_q <= 1'b0;
			st_q    <= spfs_pkg::ST_OK;
			if (!built_q) begin
				st_q <= spfs_pkg::ST_UNBUILT;
			end else if (v_q > built_lim_q) begin
				st_q <= spfs_pkg::ST_RANGE;
			end else if (v_q < VW'(2)) begin
				sf_q <= v_q;
			end else begin
				sf_q    <= rd_q;
				prime_q <= (rd_q == v_q);
			end
		end
	end

	assign smallest_factor = sf_q;
	assign is_prime        = prime_q;
	assign status          = st_q;

endmodule

### rtl/smallest_prime_factor_sieve.sv
// A build transaction fills a smallest-prime-factor table for 0 up to the
// configured limit (saturated to MAX_N, at most 8191) and returns one done
// result; a query transaction returns the factor, a prime flag and a status.
// A query result passes from one read of the table into the read register and
// then into the result register once the output register is free. A build of
// limit L first initializes the table entries 0 up to L, then reads and checks
// each odd candidate p with p*p <= L plus one final check, and for each prime
// steps over every multiple from p*p up to L, all through the one write and
// one read port of the table. The table needs no clearing after reset. Inputs
// are taken only while no transaction is in progress; a finished result may
// wait in the output register meanwhile.
module smallest_prime_factor_sieve #(
	parameter int unsigned MAX_N = spfs_pkg::MAX_N_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [spfs_pkg::VW-1:0] cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    command,
	input  logic [spfs_pkg::VW-1:0] query_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [spfs_pkg::VW-1:0] smallest_factor,
	output logic                    is_prime,
	output logic [1:0]              status
);

	spfs_pkg::spfs_cmd_t  cmd;
	spfs_pkg::spfs_stat_t stat;

	spfs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	spfs_dp #(
		.MAX_N (MAX_N)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.query_value     (query_value),
		.cmd             (cmd),
		.stat            (stat),
		.smallest_factor (smallest_factor),
		.is_prime        (is_prime),
		.status          (status)
	);

endmodule

### rtl/spfs_checker.sv
// Port-level checker for the smallest-prime-factor sieve and its bind.
// Depends on spfs_pkg and attaches to smallest_prime_factor_sieve.
module spfs_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input logic [spfs_pkg::VW-1:0] smallest_factor,
	input logic                    is_prime,
	input logic [1:0]              status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(smallest_factor)
			&& $stable(is_prime) && $stable(status))
		else $error("Result changed while stalled.");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status == spfs_pkg::ST_OK || status == spfs_pkg::ST_RANGE
			|| status == spfs_pkg::ST_UNBUILT)
		else $error("Unknown status code.");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != spfs_pkg::ST_OK |-> smallest_factor == '0 && !is_prime)
		else $error("Error result carries a factor.");

	a_prime_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_prime |-> status == spfs_pkg::ST_OK && smallest_factor >= 2)
		else $error("Prime flag on an invalid result.");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("Input taken while a transaction is in progress.");

endmodule

bind smallest_prime_factor_sieve spfs_checker u_spfs_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.in_valid        (in_valid),
	.in_ready        (in_ready),
	.out_valid       (out_valid),
	.out_ready       (out_ready),
	.smallest_factor (smallest_factor),
	.is_prime        (is_prime),
	.status          (status)
);
